>>> hdl/bcomp_pkg.sv
package bcomp_pkg;

  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_AC1_AC2 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AC3_AC4 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_AC5_AC6 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_B1_B2   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MC_MD   = 3'd4;

  localparam logic [31:0] B6_OFFSET  = 32'd4000;
  localparam logic [31:0] B7_SCALE   = 32'd50000;
  localparam logic [31:0] B4_BIAS    = 32'd32768;
  localparam logic [31:0] B3_ROUND   = 32'd2;
  localparam logic [31:0] T_ROUND    = 32'd8;
  localparam logic [31:0] P_COEF_SQ  = 32'd3038;
  localparam logic [31:0] P_COEF_LIN = 32'hFFFF_E343;  // -7357
  localparam logic [31:0] P_ROUND    = 32'd3791;

  localparam logic [4:0] DIV_LAST = 5'd31;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RUN  = 4'b0010,
    S_DIV  = 4'b0100,
    S_OUT  = 4'b1000
  } state_e;

  typedef enum logic [4:0] {
    ST_T0  = 5'd0,
    ST_T1  = 5'd1,
    ST_T2  = 5'd2,
    ST_T3  = 5'd3,
    ST_T4  = 5'd4,
    ST_P0  = 5'd5,
    ST_P1  = 5'd6,
    ST_P2  = 5'd7,
    ST_P3  = 5'd8,
    ST_P4  = 5'd9,
    ST_P5  = 5'd10,
    ST_P6  = 5'd11,
    ST_P7  = 5'd12,
    ST_P8  = 5'd13,
    ST_P9  = 5'd14,
    ST_P10 = 5'd15,
    ST_P11 = 5'd16,
    ST_P12 = 5'd17,
    ST_P13 = 5'd18,
    ST_P14 = 5'd19,
    ST_P15 = 5'd20,
    ST_P16 = 5'd21
  } step_e;

  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quotient;
  } div_rsp_t;

  function automatic logic [31:0] sext16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] asr(input logic [31:0] v, input logic [4:0] s);
    return 32'($signed(v) >>> s);
  endfunction

endpackage

>>> hdl/bcomp_mul.sv
module bcomp_mul (
  input  logic        clk_i,
  input  logic [31:0] op_a_i,
  input  logic [31:0] op_b_i,
  output logic [31:0] prod_o
);

  logic [31:0] prod_d;
  logic [31:0] prod_q;

  // low word is the same for signed and unsigned operands
  assign prod_d = 32'(op_a_i * op_b_i);

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  assign prod_o = prod_q;

endmodule

>>> hdl/bcomp_div.sv
module bcomp_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bcomp_pkg::div_req_t req_i,
  output bcomp_pkg::div_rsp_t rsp_o
);

  logic        active_q;
  logic        done_q;
  logic [4:0]  cnt_q;
  logic [31:0] rem_q;
  logic [31:0] quo_q;
  logic [31:0] dvs_q;
  logic [32:0] rem_sh;
  logic [32:0] diff;

  assign rem_sh = {rem_q, quo_q[31]};
  assign diff   = rem_sh - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      done_q   <= 1'b0;
      cnt_q    <= '0;
    end else begin
      done_q <= active_q && (cnt_q == bcomp_pkg::DIV_LAST);
      if (req_i.start) begin
        active_q <= 1'b1;
        cnt_q    <= '0;
      end else if (active_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == bcomp_pkg::DIV_LAST) begin
          active_q <= 1'b0;
        end
      end
    end
  end

  // restoring divide, one quotient bit per cycle
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
    end else if (active_q) begin
      if (!diff[32]) begin
        rem_q <= diff[31:0];
        quo_q <= {quo_q[30:0], 1'b1};
      end else begin
        rem_q <= rem_sh[31:0];
        quo_q <= {quo_q[30:0], 1'b0};
      end
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

>>> hdl/baro_temp_pressure_compensation.sv
// Barometric sensor compensation. Each input beat carries one raw 16-bit sample, tagged in
// tuser as temperature (0) or pressure (1); each gives exactly one output beat with the
// compensated value (0.1 degree units or pascals, oversampling zero) and a divide error flag
// that forces the value to zero. A temperature sample updates the stored b5 that later
// pressure samples use (b5 is zero after reset). The ten calibration coefficients are
// written two per register through the cfg port; the user must write them only while the
// block is idle, which the block itself does not enforce. One shared 32x32 multiplier and a
// 32-step restoring divider are run by a step sequencer, so the block takes one sample at a
// time, most of its time per sample spent in the divider, plus any output backpressure. A
// finished result sits in the output register while the next sample is accepted.
module baro_temp_pressure_compensation (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [bcomp_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [31:0]                    cfg_data_i,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  logic [15:0]                    s_axis_tdata_i,  // raw_value
  input  logic                           s_axis_tuser_i,  // kind
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  output logic [31:0]                    m_axis_tdata_o,  // value
  output logic [1:0]                     m_axis_tuser_o   // div_error (bit 1), result_kind (bit 0)
);

  bcomp_pkg::state_e   state_q, state_d;
  bcomp_pkg::step_e    step_q, step_d;
  bcomp_pkg::div_req_t div_req;
  bcomp_pkg::div_rsp_t div_rsp;

  logic [31:0] coef_q [5];

  logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
  logic [31:0] mc_sh;
  logic [31:0] mul_a, mul_b, prod;

  logic        s_acc, out_load;
  logic        kind_q;
  logic [31:0] raw_q;
  logic [31:0] b5_q;
  logic [31:0] x1_q, den_q;
  logic        neg_q, big_q;
  logic [31:0] b6_q, sq_q, t_q, u_q, b3_q, b4_q, b7_q, p_q;
  logic [31:0] res_q;
  logic        err_q;
  logic        m_valid_q;
  logic        m_kind_q, m_err_q;
  logic [31:0] m_val_q;

  assign ac1 = bcomp_pkg::sext16(coef_q[0][31:16]);
  assign ac2 = bcomp_pkg::sext16(coef_q[0][15:0]);
  assign ac3 = bcomp_pkg::sext16(coef_q[1][31:16]);
  assign ac4 = {16'b0, coef_q[1][15:0]};
  assign ac5 = {16'b0, coef_q[2][31:16]};
  assign ac6 = {16'b0, coef_q[2][15:0]};
  assign b1  = bcomp_pkg::sext16(coef_q[3][31:16]);
  assign b2  = bcomp_pkg::sext16(coef_q[3][15:0]);
  assign mc  = bcomp_pkg::sext16(coef_q[4][31:16]);
  assign md  = bcomp_pkg::sext16(coef_q[4][15:0]);
  assign mc_sh = {mc[20:0], 11'b0};

  assign s_axis_tready_o = (state_q == bcomp_pkg::S_IDLE);
  assign s_acc           = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 5; i++) begin
        coef_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        bcomp_pkg::CFG_AC1_AC2: coef_q[0] <= cfg_data_i;
        bcomp_pkg::CFG_AC3_AC4: coef_q[1] <= cfg_data_i;
        bcomp_pkg::CFG_AC5_AC6: coef_q[2] <= cfg_data_i;
        bcomp_pkg::CFG_B1_B2:   coef_q[3] <= cfg_data_i;
        bcomp_pkg::CFG_MC_MD:   coef_q[4] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  bcomp_mul u_mul (
    .clk_i  (clk_i),
    .op_a_i (mul_a),
    .op_b_i (mul_b),
    .prod_o (prod)
  );

  bcomp_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // multiplier operand select, product is consumed in the next step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (step_q)
      bcomp_pkg::ST_T0: begin
        mul_a = raw_q;
        mul_b = ac5;
      end
      bcomp_pkg::ST_P1: begin
        mul_a = b6_q;
        mul_b = b6_q;
      end
      bcomp_pkg::ST_P2: begin
        mul_a = ac2;
        mul_b = b6_q;
      end
      bcomp_pkg::ST_P3: begin
        mul_a = b2;
        mul_b = sq_q;
      end
      bcomp_pkg::ST_P4: begin
        mul_a = ac3;
        mul_b = b6_q;
      end
      bcomp_pkg::ST_P5: begin
        mul_a = b1;
        mul_b = sq_q;
      end
      bcomp_pkg::ST_P7: begin
        mul_a = b3_q;
        mul_b = bcomp_pkg::B7_SCALE;
      end
      bcomp_pkg::ST_P8: begin
        mul_a = ac4;
        mul_b = t_q;
      end
      bcomp_pkg::ST_P12: begin
        mul_a = bcomp_pkg::asr(p_q, 5'd8);
        mul_b = bcomp_pkg::asr(p_q, 5'd8);
      end
      bcomp_pkg::ST_P13: begin
        mul_a = prod;
        mul_b = bcomp_pkg::P_COEF_SQ;
      end
      bcomp_pkg::ST_P14: begin
        mul_a = bcomp_pkg::P_COEF_LIN;
        mul_b = p_q;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d          = state_q;
    step_d           = step_q;
    div_req.start    = 1'b0;
    div_req.dividend = '0;
    div_req.divisor  = '0;
    out_load         = 1'b0;
    case (state_q)
      bcomp_pkg::S_IDLE: begin
        if (s_acc) begin
          state_d = bcomp_pkg::S_RUN;
          step_d  = s_axis_tuser_i ? bcomp_pkg::ST_P0 : bcomp_pkg::ST_T0;
        end
      end
      bcomp_pkg::S_RUN: begin
        step_d = bcomp_pkg::step_e'(step_q + 5'd1);
        case (step_q)
          bcomp_pkg::ST_T2: begin
            if (den_q == '0) begin
              state_d = bcomp_pkg::S_OUT;
            end else begin
              state_d          = bcomp_pkg::S_DIV;
              div_req.start    = 1'b1;
              div_req.dividend = mc_sh[31] ? 32'(0 - mc_sh) : mc_sh;
              div_req.divisor  = den_q[31] ? 32'(0 - den_q) : den_q;
            end
          end
          bcomp_pkg::ST_P10: begin
            if (b4_q == '0) begin
              state_d = bcomp_pkg::S_OUT;
            end else begin
              state_d          = bcomp_pkg::S_DIV;
              div_req.start    = 1'b1;
              div_req.dividend = b7_q[31] ? b7_q : {b7_q[30:0], 1'b0};
              div_req.divisor  = b4_q;
            end
          end
          bcomp_pkg::ST_T4, bcomp_pkg::ST_P16: begin
            state_d = bcomp_pkg::S_OUT;
          end
          default: ;
        endcase
      end
      bcomp_pkg::S_DIV: begin
        if (div_rsp.done) begin
          state_d = bcomp_pkg::S_RUN;
        end
      end
      bcomp_pkg::S_OUT: begin
        if (!m_valid_q || m_axis_tready_i) begin
          out_load = 1'b1;
          state_d  = bcomp_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = bcomp_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= bcomp_pkg::S_IDLE;
      step_q    <= bcomp_pkg::ST_T0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // stored b5, kept across samples
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b5_q <= '0;
    end else if (state_q == bcomp_pkg::S_RUN) begin
      if (step_q == bcomp_pkg::ST_T2 && den_q == '0) begin
        b5_q <= x1_q;
      end else if (step_q == bcomp_pkg::ST_T3) begin
        b5_q <= x1_q + (neg_q ? 32'(0 - div_rsp.quotient) : div_rsp.quotient);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      kind_q <= s_axis_tuser_i;
      err_q  <= 1'b0;
      raw_q  <= s_axis_tuser_i ? {16'b0, s_axis_tdata_i} : ({16'b0, s_axis_tdata_i} - ac6);
    end
    if (state_q == bcomp_pkg::S_RUN) begin
      case (step_q)
        bcomp_pkg::ST_T1: begin
          x1_q  <= bcomp_pkg::asr(prod, 5'd15);
          den_q <= bcomp_pkg::asr(prod, 5'd15) + md;
        end
        bcomp_pkg::ST_T2: begin
          neg_q <= mc_sh[31] ^ den_q[31];
          if (den_q == '0) begin
            err_q <= 1'b1;
            res_q <= '0;
          end
        end
        bcomp_pkg::ST_T4: begin
          res_q <= bcomp_pkg::asr(b5_q + bcomp_pkg::T_ROUND, 5'd4);
        end
        bcomp_pkg::ST_P0: begin
          b6_q <= b5_q - bcomp_pkg::B6_OFFSET;
        end
        bcomp_pkg::ST_P2: begin
          sq_q <= bcomp_pkg::asr(prod, 5'd12);
        end
        bcomp_pkg::ST_P3: begin
          t_q <= bcomp_pkg::asr(prod, 5'd11);
        end
        bcomp_pkg::ST_P4: begin
          t_q <= bcomp_pkg::asr(prod, 5'd11) + t_q;
        end
        bcomp_pkg::ST_P5: begin
          u_q  <= bcomp_pkg::asr(prod, 5'd13);
          b3_q <= bcomp_pkg::asr({ac1[29:0], 2'b0} + t_q + bcomp_pkg::B3_ROUND, 5'd2);
        end
        bcomp_pkg::ST_P6: begin
          t_q  <= bcomp_pkg::asr(u_q + bcomp_pkg::asr(prod, 5'd16) + bcomp_pkg::B3_ROUND,
                                 5'd2);
          b3_q <= raw_q - b3_q;
        end
        bcomp_pkg::ST_P7: begin
          t_q <= t_q + bcomp_pkg::B4_BIAS;
        end
        bcomp_pkg::ST_P8: begin
          b7_q <= prod;
        end
        bcomp_pkg::ST_P9: begin
          b4_q <= {15'b0, prod[31:15]};
        end
        bcomp_pkg::ST_P10: begin
          big_q <= b7_q[31];
          if (b4_q == '0) begin
            err_q <= 1'b1;
            res_q <= '0;
          end
        end
        bcomp_pkg::ST_P11: begin
          p_q <= big_q ? {div_rsp.quotient[30:0], 1'b0} : div_rsp.quotient;
        end
        bcomp_pkg::ST_P14: begin
          u_q <= bcomp_pkg::asr(prod, 5'd16);
        end
        bcomp_pkg::ST_P15: begin
          t_q <= u_q + bcomp_pkg::asr(prod, 5'd16) + bcomp_pkg::P_ROUND;
        end
        bcomp_pkg::ST_P16: begin
          res_q <= p_q + bcomp_pkg::asr(t_q, 5'd4);
        end
        default: ;
      endcase
    end
    if (out_load) begin
      m_kind_q <= kind_q;
      m_val_q  <= res_q;
      m_err_q  <= err_q;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_val_q;
  assign m_axis_tuser_o  = {m_err_q, m_kind_q};

endmodule

>>> hdl/bcomp_chk.sv
module bcomp_chk (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid_i,
  input logic                            s_axis_tready_o,
  input logic                            m_axis_tvalid_o,
  input logic                            m_axis_tready_i,
  input logic [31:0]                     m_axis_tdata_o,
  input logic [1:0]                      m_axis_tuser_o
);

  // one sample at a time: busy right after a beat is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("input taken while busy");

  // an error result always carries a zero value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o[1]) |-> (m_axis_tdata_o == '0))
    else $error("div error with nonzero value");

  // with no result pending, none can show up the cycle after a sample is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o && !m_axis_tvalid_o) |=> !m_axis_tvalid_o)
    else $error("result too early");

  // stalled result beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=>
      (m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o)))
    else $error("output beat changed under stall");

endmodule

bind baro_temp_pressure_compensation bcomp_chk u_bcomp_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);
